// ===== rtl/core/qfas_pkg.sv =====
// Package: item types, class codes and helper functions for the quad add/subtract unit.
package qfas_pkg;

  localparam int unsigned SIG_BITS = 113;
  localparam int unsigned EXP_BITS = 16;
  localparam int unsigned HI_BITS  = SIG_BITS - 64;
  localparam int unsigned WIDE     = 128;
  localparam int unsigned LZ_BITS  = $clog2(SIG_BITS);
  localparam int unsigned XEXP     = EXP_BITS + 2;

  localparam logic [2:0] CLS_ZERO = 3'd0;
  localparam logic [2:0] CLS_SUB  = 3'd1;
  localparam logic [2:0] CLS_NORM = 3'd2;
  localparam logic [2:0] CLS_INF  = 3'd3;
  localparam logic [2:0] CLS_QNAN = 3'd4;
  localparam logic [2:0] CLS_SNAN = 3'd5;

  localparam logic [1:0] RM_NEAREST = 2'd0;
  localparam logic [1:0] RM_ZERO    = 2'd1;
  localparam logic [1:0] RM_PLUS    = 2'd2;
  localparam logic [1:0] RM_MINUS   = 2'd3;

  typedef struct packed {
    logic                       action;
    logic [2:0]                 a_class;
    logic                       a_sign;
    logic signed [EXP_BITS-1:0] a_exponent;
    logic [HI_BITS-1:0]         a_sig_high;
    logic [63:0]                a_sig_low;
    logic [2:0]                 b_class;
    logic                       b_sign;
    logic signed [EXP_BITS-1:0] b_exponent;
    logic [HI_BITS-1:0]         b_sig_high;
    logic [63:0]                b_sig_low;
  } in_item_t;

  typedef struct packed {
    logic [2:0]                 res_class;
    logic                       res_sign;
    logic signed [EXP_BITS-1:0] res_exponent;
    logic [HI_BITS-1:0]         res_sig_high;
    logic [63:0]                res_sig_low;
    logic                       round_bit;
    logic                       sticky_bit;
    logic                       invalid;
  } out_item_t;

  typedef struct packed {
    logic [2:0]                 cls;
    logic                       sign;
    logic signed [EXP_BITS-1:0] exp;
    logic [WIDE-1:0]            sig;
  } operand_t;

  typedef struct packed {
    logic [WIDE-1:0] sig;
    logic            r;
    logic            s;
  } shr_t;

  // Saturate a widened exponent back into EXP_BITS.
  function automatic logic signed [EXP_BITS-1:0] sat_exp(input logic signed [XEXP-1:0] v);
    logic signed [XEXP-1:0] hi;
    logic signed [XEXP-1:0] lo;
    hi = XEXP'((1 << (EXP_BITS - 1)) - 1);
    lo = -XEXP'(1 << (EXP_BITS - 1));
    if (v > hi) begin
      return hi[EXP_BITS-1:0];
    end else if (v < lo) begin
      return lo[EXP_BITS-1:0];
    end
    return v[EXP_BITS-1:0];
  endfunction

  function automatic logic signed [XEXP-1:0] xexp(input logic signed [EXP_BITS-1:0] e);
    return XEXP'(e);
  endfunction

  // Right shift by n (n >= 0), returning first shifted-out bit and OR of the rest.
  function automatic shr_t shift_rs(input logic [WIDE-1:0] v, input logic [XEXP-1:0] n);
    shr_t       o;
    logic [7:0] k;
    logic [7:0] km1;
    o.sig = v;
    o.r   = 1'b0;
    o.s   = 1'b0;
    k     = (n > XEXP'(WIDE)) ? 8'(WIDE) : n[7:0];
    km1   = k - 8'd1;
    if (n != '0) begin
      o.s   = |(v & ~({WIDE{1'b1}} << km1[6:0]));
      o.r   = v[km1[6:0]];
      o.sig = v >> k;
    end
    return o;
  endfunction

  // Leading zeros above the top significand bit; zero input counts 0.
  function automatic logic [LZ_BITS-1:0] lead_zeros(input logic [SIG_BITS-1:0] v);
    logic [LZ_BITS-1:0] c;
    c = '0;
    for (int i = 0; i < SIG_BITS; i++) begin
      if (v[i]) c = LZ_BITS'(SIG_BITS - 1 - i);
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/qfas_core.sv =====
// Combinational datapath: operand ordering, alignment, add/subtract and renormalization.
module qfas_core import qfas_pkg::*; (
  input  in_item_t  item_i,
  input  logic [1:0] rounding_mode_i,
  output out_item_t item_o
);

  operand_t a, b, x, y, p, q, z;
  shr_t     sh;
  logic [WIDE-1:0] sum, d, t;
  logic signed [XEXP-1:0] diff;
  logic [LZ_BITS-1:0] lz;
  logic r, s, g, inv;

  always_comb begin
    a.cls  = (item_i.a_class > CLS_SNAN) ? CLS_SNAN : item_i.a_class;
    a.sign = item_i.a_sign;
    a.exp  = item_i.a_exponent;
    a.sig  = WIDE'({item_i.a_sig_high, item_i.a_sig_low});
    b.cls  = (item_i.b_class > CLS_SNAN) ? CLS_SNAN : item_i.b_class;
    b.sign = item_i.b_sign ^ (item_i.action && (b.cls < CLS_QNAN));
    b.exp  = item_i.b_exponent;
    b.sig  = WIDE'({item_i.b_sig_high, item_i.b_sig_low});

    // class order first, then exponent order
    if (a.cls < b.cls) begin
      x = b; y = a;
    end else begin
      x = a; y = b;
    end
    if (x.exp < y.exp) begin
      p = y; q = x;
    end else begin
      p = x; q = y;
    end
    diff = xexp(p.exp) - xexp(q.exp);

    z   = x;
    r   = 1'b0;
    s   = 1'b0;
    inv = 1'b0;
    sh  = shift_rs(q.sig, diff);
    sum = '0;
    d   = '0;
    t   = '0;
    g   = 1'b0;
    lz  = '0;

    if (a.sign == b.sign) begin
      if (!(x.cls == CLS_ZERO || x.cls >= CLS_INF || y.cls == CLS_ZERO)) begin
        z   = p;
        sum = p.sig + sh.sig;
        if (|sum[WIDE-1:SIG_BITS]) begin
          s     = sh.s | sh.r;
          r     = sum[0];
          sum   = sum >> 1;
          z.exp = sat_exp(xexp(p.exp) + XEXP'(1));
        end else begin
          r = sh.r;
          s = sh.s;
        end
        z.sig = sum;
      end
    end else if (x.cls >= CLS_QNAN) begin
      z = x;
    end else if (x.cls == CLS_INF) begin
      if (y.cls == CLS_INF) begin
        z.cls  = CLS_QNAN;
        z.sign = 1'b0;
        z.sig  = WIDE'({SIG_BITS{1'b1}});
        inv    = 1'b1;
      end
    end else if (x.cls == CLS_ZERO) begin
      z.sign = (rounding_mode_i == RM_MINUS);
    end else if (y.cls != CLS_ZERO) begin
      z = p;
      if (diff == '0) begin
        d = p.sig - q.sig;
        if (d == '0) begin
          z.cls  = CLS_ZERO;
          z.sign = (rounding_mode_i == RM_MINUS);
          z.sig  = '0;
        end else begin
          if (|d[WIDE-1:SIG_BITS]) begin
            z.sign = q.sign;
            d      = '0 - d;
          end
          lz    = lead_zeros(d[SIG_BITS-1:0]);
          z.sig = d << lz;
          z.exp = sat_exp(xexp(p.exp) - XEXP'(lz));
        end
      end else begin
        sh = shift_rs(q.sig, diff - XEXP'(1));
        r  = sh.r;
        s  = sh.s;
        g  = sh.sig[0];
        sh.sig = sh.sig >> 1;
        if (s) r = ~r;
        if (r | s) g = ~g;
        d = p.sig - sh.sig - WIDE'(g | r | s);
        if (|d[WIDE-1:SIG_BITS-1]) begin
          s     = s | r;
          r     = g;
          z.sig = d;
        end else begin
          t     = {d[WIDE-2:0], g};
          lz    = lead_zeros(t[SIG_BITS-1:0]);
          z.sig = t << lz;
          z.exp = sat_exp(xexp(p.exp) - XEXP'(1) - XEXP'(lz));
        end
      end
    end

    item_o.res_class    = z.cls;
    item_o.res_sign     = z.sign;
    item_o.res_exponent = z.exp;
    item_o.res_sig_high = z.sig[SIG_BITS-1:64];
    item_o.res_sig_low  = z.sig[63:0];
    item_o.round_bit    = r;
    item_o.sticky_bit   = s;
    item_o.invalid      = inv;
  end

endmodule

// ===== rtl/core/quad_float_add_sub_unpacked.sv =====
// Top level: quad-precision unpacked add/subtract with input and result registers.
//
//  channel | direction | payload      | handshake
//  in      | input     | in_item_t    | in_valid_i / in_stall_o
//  out     | output    | out_item_t   | out_valid_o / out_stall_i
//  cfg     | input     | rounding mode| cfg_we_i (no wait)
//
// An item passes through the input register and then the result
// register. One item is accepted every cycle while the output is not
// stalled; the whole datapath sits between the two registers.
// Reset clears the valid flags and the rounding mode (round to nearest).
// A stall on the output holds the result register; the input register
// then holds too and in_stall_o rises only once it is occupied.
module quad_float_add_sub_unpacked import qfas_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_item_t   in_item_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_item_o
);

  logic [1:0] rmode_q;
  logic       s1_valid_q;
  in_item_t   s1_item_q;
  logic       out_valid_q;
  out_item_t  out_item_q;
  out_item_t  res;
  logic       out_adv;
  logic       s1_adv;

  // result register can take a new item when empty or being drained
  assign out_adv    = !out_valid_q || !out_stall_i;
  assign s1_adv     = !s1_valid_q || out_adv;
  assign in_stall_o = !s1_adv;

  qfas_core u_core (
    .item_i          (s1_item_q),
    .rounding_mode_i (rmode_q),
    .item_o          (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rmode_q     <= RM_NEAREST;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) rmode_q <= cfg_wdata_i;
      if (s1_adv) s1_valid_q <= in_valid_i;
      if (out_adv) out_valid_q <= s1_valid_q;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (s1_adv && in_valid_i) s1_item_q <= in_item_i;
    if (out_adv && s1_valid_q) out_item_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== dv/quad_float_add_sub_unpacked_tb.sv =====
// Testbench: random and directed add/subtract items checked against an in-bench predictor.
module quad_float_add_sub_unpacked_tb;
  import qfas_pkg::*;

  localparam int unsigned N_RANDOM  = 1030;
  localparam int unsigned WDOG_MAX  = 5000;
  localparam int unsigned DRAIN_CYC = 8;

  typedef logic [127:0] sig_t;

  // Scoreboard: queue of predicted results, compared in order.
  class sum_board;
    out_item_t pending[$];
    int unsigned errors;
    int unsigned checked;

    function void note_input(out_item_t exp_item);
      pending.push_back(exp_item);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        $display("%0t: result with no item pending, actual %h", $realtime, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.res_class !== want.res_class)
        report("res_class", want.res_class, got.res_class);
      if (got.res_sign !== want.res_sign)
        report("res_sign", want.res_sign, got.res_sign);
      if (got.res_exponent !== want.res_exponent)
        report("res_exponent", want.res_exponent, got.res_exponent);
      if (got.res_sig_high !== want.res_sig_high)
        report("res_sig_high", want.res_sig_high, got.res_sig_high);
      if (got.res_sig_low !== want.res_sig_low)
        report("res_sig_low", want.res_sig_low, got.res_sig_low);
      if (got.round_bit !== want.round_bit)
        report("round_bit", want.round_bit, got.round_bit);
      if (got.sticky_bit !== want.sticky_bit)
        report("sticky_bit", want.sticky_bit, got.sticky_bit);
      if (got.invalid !== want.invalid)
        report("invalid", want.invalid, got.invalid);
    endfunction

    function void report(string fld, logic [127:0] want, logic [127:0] got);
      $display("%0t: mismatch %s expected %h actual %h", $realtime, fld, want, got);
      errors++;
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      cfg_we;
  logic [1:0] cfg_wdata;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  sum_board  board;
  logic [1:0] round_mode;      // predictor's copy of the register
  bit        feed_done;
  bit        hold_long;        // asks the receiver for one long stall
  int unsigned idle_cycles;
  int unsigned n_sent;

  quad_float_add_sub_unpacked u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  typedef struct {
    logic [2:0]  cls;
    logic        sign;
    int          ex;
    sig_t        sig;
  } opnd_t;

  // Mask of the significand width.
  localparam sig_t SIG_MASK = (sig_t'(1) << SIG_BITS) - 1;

  function automatic int clamp_exp(int e);
    if (e > 32767) return 32767;
    if (e < -32768) return -32768;
    return e;
  endfunction

  // Right shift folding lost bits into round and sticky.
  function automatic sig_t shr_fold(sig_t v, int n, inout logic r, inout logic s);
    int k;
    if (n <= 0) return v;
    k = (n > 128) ? 128 : n;
    s = s | r | ((k > 1) ? |(v & ((sig_t'(1) << (k - 1)) - 1)) : 1'b0);
    r = v[k - 1];
    return (k >= 128) ? sig_t'(0) : (v >> k);
  endfunction

  function automatic void renorm(inout opnd_t z);
    for (int i = 0; i < 128; i++) begin
      if (z.sig[SIG_BITS-1] || z.sig == 0) break;
      z.sig = z.sig << 1;
      z.ex  = clamp_exp(z.ex - 1);
    end
  endfunction

  function automatic opnd_t unpack_op(logic [2:0] c, logic sg, logic signed [15:0] e,
                                      logic [48:0] hi, logic [63:0] lo);
    opnd_t o;
    o.cls  = (c > CLS_SNAN) ? CLS_SNAN : c;
    o.sign = sg;
    o.ex   = e;
    o.sig  = {15'd0, hi, lo} & SIG_MASK;
    return o;
  endfunction

  function automatic out_item_t predict_sum(in_item_t it);
    opnd_t a, b, x, y, t, z;
    logic  r, s, g, rr, ss, inv;
    sig_t  d;
    out_item_t o;
    r = 0; s = 0; rr = 0; ss = 0; inv = 0;
    a = unpack_op(it.a_class, it.a_sign, it.a_exponent, it.a_sig_high, it.a_sig_low);
    b = unpack_op(it.b_class, it.b_sign, it.b_exponent, it.b_sig_high, it.b_sig_low);
    if (it.action && b.cls < CLS_QNAN) b.sign = ~b.sign;
    x = a; y = b;
    if (x.cls < y.cls) begin t = x; x = y; y = t; end
    z = x;
    if (a.sign == b.sign) begin
      // magnitude add
      if (!(x.cls == CLS_ZERO || x.cls >= CLS_INF || y.cls == CLS_ZERO)) begin
        if (x.ex < y.ex) begin t = x; x = y; y = t; end
        z = x;
        if (x.ex != y.ex) y.sig = shr_fold(y.sig, x.ex - y.ex, r, s);
        d = x.sig + y.sig;
        if ((d >> SIG_BITS) != 0) begin
          d = shr_fold(d, 1, r, s);
          z.ex = clamp_exp(z.ex + 1);
        end
        z.sig = d; rr = r; ss = s;
      end
    end else if (x.cls >= CLS_QNAN) begin
      z = x;
    end else if (x.cls == CLS_INF) begin
      if (y.cls == CLS_INF) begin
        z.cls = CLS_QNAN; z.sign = 0; z.sig = SIG_MASK; inv = 1;
      end
    end else if (x.cls == CLS_ZERO) begin
      z.sign = (round_mode == RM_MINUS);
    end else if (y.cls != CLS_ZERO) begin
      if (x.ex < y.ex) begin t = x; x = y; y = t; end
      z = x;
      if (x.ex == y.ex) begin
        d = x.sig - y.sig;
        if (d == 0) begin
          z.cls = CLS_ZERO; z.sign = (round_mode == RM_MINUS); z.sig = 0;
        end else begin
          if ((d >> SIG_BITS) != 0) begin
            z.sign = y.sign; d = -d;
          end
          z.sig = d;
          renorm(z);
        end
      end else begin
        y.sig = shr_fold(y.sig, x.ex - y.ex - 1, r, s);
        g = y.sig[0];
        y.sig = y.sig >> 1;
        if (s) r = ~r;
        if (r | s) g = ~g;
        d = x.sig - y.sig - sig_t'(g | r | s);
        if ((d >> (SIG_BITS - 1)) != 0) begin
          ss = s | r; rr = g; z.sig = d;
        end else begin
          ss = s; rr = r;
          z.sig = {d[126:0], g};
          z.ex = clamp_exp(z.ex - 1);
          if (!z.sig[SIG_BITS-1]) renorm(z);
        end
      end
    end
    d = z.sig & SIG_MASK;
    o.res_class    = z.cls;
    o.res_sign     = z.sign;
    o.res_exponent = 16'(clamp_exp(z.ex));
    o.res_sig_high = d[112:64];
    o.res_sig_low  = d[63:0];
    o.round_bit    = rr;
    o.sticky_bit   = ss;
    o.invalid      = inv;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic signed [15:0] rand_exp();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff - 16'($urandom_range(0, 3));
      1: return 16'sh8000 + 16'($urandom_range(0, 3));
      2: return 16'($urandom());
      default: return 16'($signed($urandom_range(0, 300)) - 150);
    endcase
  endfunction

  // Mostly normal significands; some odd shapes and sparse bits.
  function automatic void rand_sig(output logic [48:0] hi, output logic [63:0] lo);
    hi = 49'({$urandom(), $urandom()});
    lo = rand64();
    case ($urandom_range(0, 7))
      0: hi[48] = 1'b0;
      1: begin hi = 49'd1 << 48; lo = '0; end
      2: begin hi = '1; lo = '1; end
      3: lo = lo & 64'hff;
      default: hi[48] = 1'b1;
    endcase
  endfunction

  function automatic logic [2:0] rand_class();
    int p;
    p = $urandom_range(0, 19);
    if (p < 12) return CLS_NORM;
    if (p == 19) return 3'($urandom_range(6, 7));
    return 3'($urandom_range(0, 5));
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    logic [48:0] h;
    logic [63:0] l;
    it.action = 1'($urandom_range(0, 1));
    it.a_class = rand_class();
    it.a_sign = 1'($urandom_range(0, 1));
    it.a_exponent = rand_exp();
    rand_sig(h, l);
    it.a_sig_high = h; it.a_sig_low = l;
    it.b_class = rand_class();
    it.b_sign = 1'($urandom_range(0, 1));
    // close exponents exercise cancellation and alignment
    if ($urandom_range(0, 2) != 0)
      it.b_exponent = it.a_exponent + 16'($signed($urandom_range(0, 8)) - 4);
    else
      it.b_exponent = rand_exp();
    rand_sig(h, l);
    it.b_sig_high = h; it.b_sig_low = l;
    // equal operands give exact zero differences
    if ($urandom_range(0, 15) == 0) begin
      it.b_exponent = it.a_exponent;
      it.b_sig_high = it.a_sig_high;
      it.b_sig_low  = it.a_sig_low;
      it.b_class    = it.a_class;
    end
    return it;
  endfunction

  function automatic in_item_t mk(logic act, logic [2:0] ac, logic as_, logic signed [15:0] ae,
                                  logic [48:0] ah, logic [63:0] al, logic [2:0] bc, logic bs,
                                  logic signed [15:0] be, logic [48:0] bh, logic [63:0] bl);
    in_item_t it;
    it = '{act, ac, as_, ae, ah, al, bc, bs, be, bh, bl};
    return it;
  endfunction

  // Offer one item; hold it until accepted. Valid stays high after the
  // accept so back-to-back items need no gap; drain() drops it.
  task automatic send_item(in_item_t it);
    int unsigned gap;
    gap = $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_input(predict_sum(it));
    n_sent++;
  endtask

  // Stop offering, wait for all outstanding results, then let the pipeline settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  // Mode changes only with the pipeline empty.
  task automatic set_mode(logic [1:0] m);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we    <= 1'b0;
    round_mode = m;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned w;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) board.check_result(out_item);
      if (hold_long) begin
        out_stall <= 1'b1;
        repeat (40) @(posedge clk);
        hold_long = 0;
        out_stall <= 1'b0;
      end else begin
        w = $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0) w = 0;
        out_stall <= (w != 0);
      end
    end
  end

  // Watchdog: cycles with no accepted item on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WDOG_MAX) begin
      $display("watchdog expired at %0t", $realtime);
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [48:0] h1;
    board     = new();
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = RM_NEAREST;
    in_valid  = 1'b0;
    in_item   = '0;
    round_mode = RM_NEAREST;
    hold_long = 0;
    n_sent    = 0;
    idle_cycles = 0;
    h1 = 49'd1 << 48;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, special classes, cancellation, zero signs.
    for (int m = 0; m < 4; m++) begin
      set_mode(2'(m));
      send_item(mk(1, CLS_ZERO, 0, 0, 0, 0, CLS_ZERO, 0, 0, 0, 0));     // zero minus zero
      send_item(mk(1, CLS_NORM, 1, 5, h1, 7, CLS_NORM, 1, 5, h1, 7));   // exact cancel
    end
    set_mode(RM_MINUS);
    send_item(mk(1, CLS_INF, 0, 16'sh7fff, h1, 0, CLS_INF, 0, 3, h1, 0));  // inf minus inf
    send_item(mk(0, CLS_INF, 0, 0, h1, 0, CLS_INF, 1, 0, h1, 0));
    send_item(mk(0, CLS_QNAN, 1, 1, '1, '1, CLS_INF, 0, 0, 0, 0));
    send_item(mk(1, CLS_NORM, 0, 0, h1, 0, CLS_SNAN, 0, 2, 49'h5, 9));
    send_item(mk(0, 3'd7, 1, 0, 0, 0, 3'd6, 0, 0, 0, 1));
    send_item(mk(0, CLS_NORM, 0, 16'sh7fff, '1, '1, CLS_NORM, 0, 16'sh7fff, '1, '1));
    send_item(mk(1, CLS_NORM, 0, 16'sh8000, h1, 0, CLS_NORM, 0, 16'sh8000, h1, 1));
    send_item(mk(1, CLS_NORM, 0, 16'sh7fff, h1, 0, CLS_NORM, 0, 16'sh8000, '1, '1));
    send_item(mk(0, CLS_SUB, 0, -16382, 49'd3, 0, CLS_ZERO, 1, 0, 0, 0));
    send_item(mk(1, CLS_NORM, 1, 10, h1, 0, CLS_NORM, 1, 9, '1, '1));
    send_item(mk(0, CLS_NORM, 0, 100, h1, 0, CLS_NORM, 0, -100, h1, 64'h1));
    drain();

    // Random phases; each mode once, ending on round to nearest.
    for (int ph = 0; ph < 4; ph++) begin
      set_mode(ph == 3 ? RM_NEAREST : 2'(3 - ph));
      for (int i = 0; i < N_RANDOM / 4; i++) begin
        if (ph == 1 && i == 20) hold_long = 1;
        send_item(rand_item());
      end
      drain();
    end

    $display("Sent %0d items, %0d results checked over all four rounding modes,",
             n_sent, board.checked);
    $display("including special classes, exponent extremes and a long output stall.");
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
